// ===== src/sap_pkg.sv =====
// ----------------------------------------------------------------------------
// sap_pkg
// Shared types and constants for the sweep-and-prune pair finder.
// ----------------------------------------------------------------------------
package sap_pkg;

  localparam int COORD_W            = 32;
  localparam int IDX_W              = 16;
  localparam int MAX_RESULTS        = 32;
  localparam int ACTIVE_DEPTH_DEF   = 32;
  localparam int BOX_CNT_W          = 17;

  typedef struct packed {
    logic signed [COORD_W-1:0] min_x;
    logic signed [COORD_W-1:0] max_x;
    logic signed [COORD_W-1:0] min_y;
    logic signed [COORD_W-1:0] max_y;
    logic signed [COORD_W-1:0] min_z;
    logic signed [COORD_W-1:0] max_z;
  } box_t;

  typedef struct packed {
    logic [IDX_W-1:0] id;
    box_t             box;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic x_keep;
    logic hit;
  } ovl_t;

endpackage

// ===== src/sap_ram.sv =====
// ----------------------------------------------------------------------------
// sap_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/sap_ovl.sv =====
// ----------------------------------------------------------------------------
// sap_ovl
// Closed-interval overlap test of the incoming box against one stored entry.
// ----------------------------------------------------------------------------
module sap_ovl import sap_pkg::*; (
  input  box_t   nb,
  input  entry_t ent,
  output ovl_t   res
);

  always_comb begin
    res.x_keep = !(ent.box.max_x < nb.min_x);
    res.hit    = res.x_keep && (nb.max_x >= ent.box.min_x) &&
                 (nb.max_y >= ent.box.min_y) && (nb.min_y <= ent.box.max_y) &&
                 (nb.max_z >= ent.box.min_z) && (nb.min_z <= ent.box.max_z);
  end

endmodule

// ===== src/aabb_sweep_prune_pairs.sv =====
// ----------------------------------------------------------------------------
// aabb_sweep_prune_pairs
// Flow: an accepted box first prunes the active list, reading and checking each
//   entry in turn (the list is empty on a frame start), is then appended, and the
//   list is walked downward until its last pair is emitted, or one empty report
//   is sent when no pair is found; output stalls hold the walk.
// Throughput: one box at a time; the next box is taken once the walk or empty report ends.
// Reset: synchronous active-low rst_n clears list count, box counter,
//   overflow and the output valid flag; RAM contents are left as they are.
// ----------------------------------------------------------------------------
module aabb_sweep_prune_pairs import sap_pkg::*; #(
  parameter int ACTIVE_DEPTH = ACTIVE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [191:0] in_tdata,   // min_x, min_y, min_z, max_x, max_y, max_z
  input  logic         in_tuser,   // frame_start
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [39:0]  out_tdata,  // new_index, other_index, overflow, zero pad
  output logic         out_tuser,  // pair_valid
  output logic         out_tlast   // last
);

  localparam int AW = (ACTIVE_DEPTH > 1) ? $clog2(ACTIVE_DEPTH) : 1;
  localparam int CW = $clog2(ACTIVE_DEPTH + 1);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_P_RD   = 7'b0000010,
    S_P_CHK  = 7'b0000100,
    S_APPEND = 7'b0001000,
    S_W_RD   = 7'b0010000,
    S_W_CHK  = 7'b0100000,
    S_EMPTY  = 7'b1000000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic [BOX_CNT_W-1:0]   bcnt_r, bcnt_nxt;
  logic                   ovf_r, ovf_nxt;
  logic [CW-1:0]          rd_i_r, rd_i_nxt;
  logic [CW-1:0]          keep_r, keep_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [CW-1:0]          j_r, j_nxt;
  logic [5:0]             emit_r, emit_nxt;
  logic [5:0]             lim_r, lim_nxt;
  box_t                   nb_r, nb_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic                   ok_r, ok_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]       out_new_r, out_new_nxt;
  logic [IDX_W-1:0]       out_other_r, out_other_nxt;
  logic                   out_ovf_r, out_ovf_nxt;
  logic                   out_pv_r, out_pv_nxt;
  logic                   out_last_r, out_last_nxt;

  logic                   we;
  logic [AW-1:0]          waddr, raddr;
  entry_t                 wdata, rdata;
  ovl_t                   ovl;
  logic                   in_acc, slot_free;
  logic [BOX_CNT_W-1:0]   bcnt_eff;
  logic [6:0]             cnt_w;
  logic [CW-1:0]          jm1;

  sap_ram #(.WIDTH(ENTRY_W), .DEPTH(ACTIVE_DEPTH), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  sap_ovl u_ovl (
    .nb  (nb_r),
    .ent (rdata),
    .res (ovl)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;
  assign bcnt_eff  = in_tuser ? '0 : bcnt_r;
  assign cnt_w     = 7'(cnt_r);
  assign jm1       = j_r - CW'(1);

  always_comb begin
    raddr = (state_r == S_W_RD || state_r == S_W_CHK) ? jm1[AW-1:0] : rd_i_r[AW-1:0];
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    bcnt_nxt      = bcnt_r;
    ovf_nxt       = ovf_r;
    rd_i_nxt      = rd_i_r;
    keep_nxt      = keep_r;
    cnt_nxt       = cnt_r;
    j_nxt         = j_r;
    emit_nxt      = emit_r;
    lim_nxt       = lim_r;
    nb_nxt        = nb_r;
    idx_nxt       = idx_r;
    ok_nxt        = ok_r;
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;
    out_new_nxt   = out_new_r;
    out_other_nxt = out_other_r;
    out_ovf_nxt   = out_ovf_r;
    out_pv_nxt    = out_pv_r;
    out_last_nxt  = out_last_r;
    we            = 1'b0;
    waddr         = keep_r[AW-1:0];
    wdata         = rdata;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          nb_nxt.min_x = in_tdata[31:0];
          nb_nxt.min_y = in_tdata[63:32];
          nb_nxt.min_z = in_tdata[95:64];
          nb_nxt.max_x = in_tdata[127:96];
          nb_nxt.max_y = in_tdata[159:128];
          nb_nxt.max_z = in_tdata[191:160];
          ok_nxt       = !bcnt_eff[BOX_CNT_W-1];
          idx_nxt      = bcnt_eff[BOX_CNT_W-1] ? '1 : bcnt_eff[IDX_W-1:0];
          bcnt_nxt     = bcnt_eff + BOX_CNT_W'(!bcnt_eff[BOX_CNT_W-1]);
          if (in_tuser) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
          end
          rd_i_nxt  = '0;
          keep_nxt  = '0;
          cnt_nxt   = '0;
          emit_nxt  = '0;
          state_nxt = (in_tuser || count_r == '0) ? S_APPEND : S_P_RD;
        end
      end
      S_P_RD: begin
        state_nxt = S_P_CHK;
      end
      S_P_CHK: begin
        if (ovl.x_keep) begin
          we       = 1'b1;
          keep_nxt = keep_r + CW'(1);
        end
        if (ovl.hit) begin
          cnt_nxt = cnt_r + CW'(1);
        end
        rd_i_nxt  = rd_i_r + CW'(1);
        state_nxt = (rd_i_r + CW'(1) == count_r) ? S_APPEND : S_P_RD;
      end
      S_APPEND: begin
        wdata.id  = idx_r;
        wdata.box = nb_r;
        if (ok_r && keep_r != CW'(ACTIVE_DEPTH)) begin
          we        = 1'b1;
          count_nxt = keep_r + CW'(1);
        end else begin
          count_nxt = keep_r;
          ovf_nxt   = 1'b1;
        end
        if (cnt_w > 7'(MAX_RESULTS)) begin
          ovf_nxt = 1'b1;
          lim_nxt = 6'(MAX_RESULTS);
        end else begin
          lim_nxt = cnt_w[5:0];
        end
        j_nxt     = keep_r;
        state_nxt = (cnt_r == '0) ? S_EMPTY : S_W_RD;
      end
      S_W_RD: begin
        state_nxt = S_W_CHK;
      end
      S_W_CHK: begin
        if (!ovl.hit || slot_free) begin
          if (ovl.hit) begin
            out_valid_nxt = 1'b1;
            out_new_nxt   = idx_r;
            out_other_nxt = rdata.id;
            out_ovf_nxt   = ovf_r;
            out_pv_nxt    = 1'b1;
            out_last_nxt  = (emit_r + 6'd1 == lim_r);
            emit_nxt      = emit_r + 6'd1;
          end
          j_nxt = jm1;
          if ((ovl.hit && emit_r + 6'd1 == lim_r) || jm1 == '0) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_W_RD;
          end
        end
      end
      S_EMPTY: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_new_nxt   = idx_r;
          out_other_nxt = '0;
          out_ovf_nxt   = ovf_r;
          out_pv_nxt    = 1'b0;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      bcnt_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      rd_i_r      <= '0;
      keep_r      <= '0;
      cnt_r       <= '0;
      j_r         <= '0;
      emit_r      <= '0;
      lim_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      bcnt_r      <= bcnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      rd_i_r      <= rd_i_nxt;
      keep_r      <= keep_nxt;
      cnt_r       <= cnt_nxt;
      j_r         <= j_nxt;
      emit_r      <= emit_nxt;
      lim_r       <= lim_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nb_r        <= nb_nxt;
    idx_r       <= idx_nxt;
    ok_r        <= ok_nxt;
    out_new_r   <= out_new_nxt;
    out_other_r <= out_other_nxt;
    out_ovf_r   <= out_ovf_nxt;
    out_pv_r    <= out_pv_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_ovf_r, out_other_r, out_new_r};
  assign out_tuser  = out_pv_r;
  assign out_tlast  = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(ACTIVE_DEPTH))
    else $error("active count above depth");

  a_compact_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_P_CHK) |-> (keep_r <= rd_i_r))
    else $error("compaction write overtakes read");

  a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    emit_r <= 6'(MAX_RESULTS))
    else $error("too many results emitted");

  a_walk_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_W_CHK) |-> (j_r != '0))
    else $error("walk read below entry zero");

endmodule
